@@ rtl/plist_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// shared sizes, operation and status codes, and the per-cell control word
// for the positional list
// ----------------------------------------------------------------------------
package plist_pkg;

   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 6;
   localparam int VAL_W  = 32;
   localparam int KIND_W = 3;
   localparam int STAT_W = 2;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

   // response status
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

   // cell operations
   localparam logic [2:0] OP_HOLD  = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_LEFT  = 3'd2;
   localparam logic [2:0] OP_RIGHT = 3'd3;
   localparam logic [2:0] OP_HEAD  = 3'd4;

   typedef struct packed {
      logic [2:0]              op;
      logic signed [VAL_W-1:0] din;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/plist_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plist request and response channels
// valid/ready channels carrying list requests and list responses
// ----------------------------------------------------------------------------
interface plist_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [plist_pkg::KIND_W-1:0]          kind;
   logic [plist_pkg::POS_W-1:0]           position;
   logic signed [plist_pkg::VAL_W-1:0]    value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface plist_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [plist_pkg::VAL_W-1:0]    value_out;
   logic [plist_pkg::STAT_W-1:0]          status;
   logic                                  last;

   modport source (output valid, output value_out, output status, output last, input ready);
   modport sink   (input valid, input value_out, input status, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/positional_list_insert_delete_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// bounded ordered list of signed 32-bit values in a row of slot cells
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one request: append at tail, insert at head, insert at
//   a position, delete at a position, or read out the whole list.
//   rsp_chan returns one status response per edit, and one response per
//   element for a read-out (head first, last marks the final one); an empty
//   list reads out as a single response with status empty.
// edits and read-out
//   an edit shifts the cells from its position on by one neighbor (an insert
//   also loads the new value) in the cycle the request is accepted, and the
//   status lands in the response register. a read-out enters the read state,
//   then, while the response register is free, the list rotates toward the
//   head one cell a cycle and cell 0 is sent out, so after fill-count steps
//   the list is back in its original order. requests are taken only between
//   read-outs; unknown kinds are accepted and dropped without a response.
// reset and stall
//   reset empties the list (fill count zero) and clears the response valid.
//   the response register holds while rsp ready is low; a new request is
//   taken only once that register is free or being drained that cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top (
   input  logic         clock,
   input  logic         reset,
   plist_req_if.sink    req_chan,
   plist_rsp_if.source  rsp_chan
);

   localparam int DEPTH = plist_pkg::DEPTH;
   localparam int CNT_W = plist_pkg::CNT_W;
   localparam int CMP_W = plist_pkg::CMP_W;
   localparam int VAL_W = plist_pkg::VAL_W;

   // controller states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                       state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [plist_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_free;
   logic                       accept;
   logic                       do_ins, do_del, do_rot;
   logic [CMP_W-1:0]           op_pos;
   logic [CMP_W-1:0]           cnt_ext;
   logic [CMP_W-1:0]           cnt_m1;
   logic [CMP_W-1:0]           pos_ext;
   logic                       full;

   logic signed [VAL_W-1:0]    cell_q [DEPTH];
   plist_pkg::cell_ctrl_type   cell_ctrl [DEPTH];

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign cnt_ext = CMP_W'(count_ff);
   assign cnt_m1  = cnt_ext - CMP_W'(1);
   assign pos_ext = CMP_W'(req_chan.position);
   assign full    = (count_ff == CNT_W'(DEPTH));

   // request decode and sequencing
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      do_ins        = 1'b0;
      do_del        = 1'b0;
      do_rot        = 1'b0;
      op_pos        = pos_ext;

      if (accept) begin
         unique case (req_chan.kind) inside
            plist_pkg::KIND_APPEND, plist_pkg::KIND_HEAD, plist_pkg::KIND_INSERT: begin
               if (req_chan.kind == plist_pkg::KIND_APPEND) begin
                  op_pos = cnt_ext;
               end else if (req_chan.kind == plist_pkg::KIND_HEAD) begin
                  op_pos = '0;
               end
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               if (op_pos > cnt_ext) begin
                  rsp_status_in = plist_pkg::ST_BADPOS;
               end else if (full) begin
                  rsp_status_in = plist_pkg::ST_FULL;
               end else begin
                  rsp_status_in = plist_pkg::ST_OK;
                  do_ins        = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            plist_pkg::KIND_DELETE: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               if (pos_ext >= cnt_ext) begin
                  rsp_status_in = plist_pkg::ST_BADPOS;
               end else begin
                  rsp_status_in = plist_pkg::ST_OK;
                  do_del        = 1'b1;
                  count_in      = count_ff - CNT_W'(1);
               end
            end
            plist_pkg::KIND_READ: begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = plist_pkg::ST_EMPTY;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in = S_READ;
                  rem_in   = count_ff;
               end
            end
            default: begin
               // unknown kind: dropped, no response
            end
         endcase
      end else if (state_ff == S_READ && out_free) begin
         // send the head and rotate the list by one toward the head
         rsp_valid_in  = 1'b1;
         rsp_value_in  = cell_q[0];
         rsp_status_in = plist_pkg::ST_OK;
         rsp_last_in   = (rem_ff == CNT_W'(1));
         do_rot        = 1'b1;
         rem_in        = rem_ff - CNT_W'(1);
         if (rem_ff == CNT_W'(1)) begin
            state_in = S_IDLE;
         end
      end
   end

   // slot cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
      logic signed [VAL_W-1:0] left_v;
      logic signed [VAL_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_lastc
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_q[i+1];
      end

      always_comb begin
         cell_ctrl[i].din = req_chan.value;
         cell_ctrl[i].op  = plist_pkg::OP_HOLD;
         if (do_ins) begin
            if (IDX == op_pos) begin
               cell_ctrl[i].op = plist_pkg::OP_LOAD;
            end else if (IDX > op_pos && IDX <= cnt_ext) begin
               cell_ctrl[i].op = plist_pkg::OP_LEFT;
            end
         end else if (do_del) begin
            if (IDX >= op_pos && IDX < cnt_m1) begin
               cell_ctrl[i].op = plist_pkg::OP_RIGHT;
            end
         end else if (do_rot) begin
            if (IDX < cnt_m1) begin
               cell_ctrl[i].op = plist_pkg::OP_RIGHT;
            end else if (IDX == cnt_m1) begin
               cell_ctrl[i].op = plist_pkg::OP_HEAD;
            end
         end
      end

      plist_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_q[0]),
         .value       (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule
`default_nettype wire

@@ rtl/plist_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plist_cell
// one list slot: holds a value, loads a new one or takes the head's or a neighbor's
// ----------------------------------------------------------------------------
module plist_cell (
   input  logic                               clock,
   input  plist_pkg::cell_ctrl_type           ctrl,
   input  logic signed [plist_pkg::VAL_W-1:0] left_value,
   input  logic signed [plist_pkg::VAL_W-1:0] right_value,
   input  logic signed [plist_pkg::VAL_W-1:0] head_value,
   output logic signed [plist_pkg::VAL_W-1:0] value
);

   logic signed [plist_pkg::VAL_W-1:0] value_ff;
   logic signed [plist_pkg::VAL_W-1:0] value_in;

   always_comb begin
      unique case (ctrl.op)
         plist_pkg::OP_LOAD:  value_in = ctrl.din;
         plist_pkg::OP_LEFT:  value_in = left_value;
         plist_pkg::OP_RIGHT: value_in = right_value;
         plist_pkg::OP_HEAD:  value_in = head_value;
         default:             value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire
